// ----- rtl/core/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg
// shared types and constants for the software timer pool
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int DEF_TIMER_SLOTS = 8;
    localparam int RESULT_CAP      = 8;
    localparam int COUNT_W         = 16;
    localparam int CODE_W          = 8;
    localparam int VALUE_W         = 8;
    localparam int NREP_W          = $clog2(RESULT_CAP + 1);

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } t_slot;

    // operation seen by the head processor
    typedef struct packed {
        logic               func;
        logic               placed;
        logic [COUNT_W-1:0] interval;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } t_op;

    // head processor result
    typedef struct packed {
        t_slot slot;
        logic  expire;
        logic  take;
    } t_head_res;

endpackage

// ----- rtl/core/stp_cell.sv -----
// ----------------------------------------------------------------------------
// stp_cell
// one timer slot of the ring, loads from its neighbor on each shift
// ----------------------------------------------------------------------------
module stp_cell
    import stp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_slot,
    output t_slot o_slot
);

    logic [COUNT_W-1:0] r_count;
    logic [CODE_W-1:0]  r_code;
    logic [VALUE_W-1:0] r_value;

    // count is control state: zero means free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_shift) begin
            r_count <= i_slot.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_code  <= i_slot.code;
            r_value <= i_slot.value;
        end
    end

    assign o_slot.count = r_count;
    assign o_slot.code  = r_code;
    assign o_slot.value = r_value;

endmodule

// ----- rtl/core/stp_proc.sv -----
// ----------------------------------------------------------------------------
// stp_proc
// head-of-ring processing: count down on tick, claim a free slot on start
// ----------------------------------------------------------------------------
module stp_proc
    import stp_pkg::*;
(
    input  t_slot     i_slot,
    input  t_op       i_op,
    output t_head_res o_res
);

    logic busy;

    assign busy = (i_slot.count != '0);

    always_comb begin
        o_res        = '0;
        o_res.slot   = i_slot;
        o_res.expire = 1'b0;
        o_res.take   = 1'b0;
        if (i_op.func == FUNC_TICK) begin
            if (busy) begin
                o_res.slot.count = i_slot.count - COUNT_W'(1);
                o_res.expire     = (i_slot.count == COUNT_W'(1));
            end
        end else begin
            if (!i_op.placed && !busy && (i_op.interval != '0)) begin
                o_res.take       = 1'b1;
                o_res.slot.count = i_op.interval;
                o_res.slot.code  = i_op.code;
                o_res.slot.value = i_op.value;
            end
        end
    end

endmodule

// ----- rtl/core/software_timer_pool_unit.sv -----
// operation: an item is taken in idle, then the ring scans every slot and a flush state follows
// a new item is accepted only back in idle, after the flush of the previous one
// the slot ring moves one slot past the head processor per cycle while it is not stalled
// a full output register stalls the ring when a new expiry must push the pending event on
// reset (synchronous, active low) frees every slot and empties the output register
// ----------------------------------------------------------------------------
// software_timer_pool_unit
// pool of one-shot countdown timers built as a rotating ring of slot cells
// ----------------------------------------------------------------------------
module software_timer_pool_unit
    import stp_pkg::*;
#(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [COUNT_W-1:0] i_interval,
    input  logic [CODE_W-1:0]  i_code_to_send,
    input  logic [VALUE_W-1:0] i_value_to_send,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [CODE_W-1:0]  o_fired_code,
    output logic [VALUE_W-1:0] o_fired_value,
    output logic               o_last_of_run
);

    localparam int STEP_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state, n_state;

    // current transaction
    t_op              r_op;
    logic [STEP_W-1:0] r_step;
    logic [NREP_W-1:0] r_nrep;

    // one expired event held back until we know whether it is the last one
    logic               r_pend_valid;
    logic [CODE_W-1:0]  r_pend_code;
    logic [VALUE_W-1:0] r_pend_value;

    // output register
    logic               r_out_valid;
    logic [CODE_W-1:0]  r_out_code;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_last;

    // ring of cells, cell 0 is the head, the processed head goes in at the tail
    t_slot     slots [TIMER_SLOTS];
    t_head_res head_res;
    logic      shift;

    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
            t_slot cell_in;
            if (g == TIMER_SLOTS - 1) begin : g_tail
                assign cell_in = head_res.slot;
            end else begin : g_mid
                assign cell_in = slots[g+1];
            end
            stp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_slot  (cell_in),
                .o_slot  (slots[g])
            );
        end
    endgenerate

    stp_proc u_proc (
        .i_slot (slots[0]),
        .i_op   (r_op),
        .o_res  (head_res)
    );

    // handshake helpers
    logic in_fire;
    logic out_free;
    logic report;
    logic push_mid;
    logic stall;
    logic last_step;
    logic flush_push;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // only the first RESULT_CAP expiries of a tick are reported
    assign report     = (r_state == S_SCAN) && head_res.expire
                        && (r_nrep < NREP_W'(RESULT_CAP));
    // a new report pushes the held one out, not marked last
    assign push_mid   = report && r_pend_valid;
    assign stall      = push_mid && !out_free;
    assign shift      = (r_state == S_SCAN) && !stall;
    assign last_step  = (r_step == STEP_W'(TIMER_SLOTS - 1));
    assign flush_push = (r_state == S_FLUSH) && r_pend_valid && out_free;

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (shift && last_step) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan control and transaction payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op.placed  <= 1'b0;
            r_step       <= '0;
            r_nrep       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_op.func     <= i_func;
                r_op.interval <= i_interval;
                r_op.code     <= i_code_to_send;
                r_op.value    <= i_value_to_send;
                r_op.placed   <= 1'b0;
                r_step        <= '0;
                r_nrep        <= '0;
                r_pend_valid  <= 1'b0;
            end else if (shift) begin
                r_step <= r_step + STEP_W'(1);
                if (head_res.take) begin
                    r_op.placed <= 1'b1;
                end
                if (report) begin
                    r_nrep       <= r_nrep + NREP_W'(1);
                    r_pend_valid <= 1'b1;
                end
            end else if (flush_push) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // held event
    always_ff @(posedge i_clk) begin
        if (shift && report) begin
            r_pend_code  <= slots[0].code;
            r_pend_value <= slots[0].value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((shift && push_mid) || flush_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((shift && push_mid) || flush_push) begin
            r_out_code  <= r_pend_code;
            r_out_value <= r_pend_value;
            r_out_last  <= flush_push;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fired_code  = r_out_code;
    assign o_fired_value = r_out_value;
    assign o_last_of_run = r_out_last;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the one-shot software timer pool
// ----------------------------------------------------------------------------
// a queue of requests (ticks and starts) is filled up front, a driver feeds
// them through the input handshake and a monitor predicts every fired event
// from its own copy of the slot counts, codes and values, then compares each
// output transaction field by field with the oldest predicted event
module testbench;
    import stp_pkg::*;

    localparam int TIMER_SLOTS = DEF_TIMER_SLOTS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 500;

    // one pending request; drain makes the driver hold it back until every
    // predicted event has been seen
    typedef struct {
        logic               func;
        logic [COUNT_W-1:0] interval;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        bit                 drain;
    } timer_req_t;

    typedef struct {
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
        logic               last;
    } fired_event_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_func = FUNC_TICK;
    logic [COUNT_W-1:0] i_interval = '0;
    logic [CODE_W-1:0]  i_code_to_send = '0;
    logic [VALUE_W-1:0] i_value_to_send = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [CODE_W-1:0]  o_fired_code;
    logic [VALUE_W-1:0] o_fired_value;
    logic               o_last_of_run;

    timer_req_t   req_queue[$];
    fired_event_t fired_queue[$];

    // predicted pool state
    logic [COUNT_W-1:0] pool_count [TIMER_SLOTS];
    logic [CODE_W-1:0]  pool_code  [TIMER_SLOTS];
    logic [VALUE_W-1:0] pool_value [TIMER_SLOTS];

    int  err_cnt = 0;
    int  cycle_cnt = 0;
    bit  req_taken = 1'b0;

    // stretch of the run where neither side idles
    wire no_idle_window = (cycle_cnt >= 2000) && (cycle_cnt < 4000);

    software_timer_pool_unit #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_interval      (i_interval),
        .i_code_to_send  (i_code_to_send),
        .i_value_to_send (i_value_to_send),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_fired_code    (o_fired_code),
        .o_fired_value   (o_fired_value),
        .o_last_of_run   (o_last_of_run)
    );

    always #1 i_clk = ~i_clk;

    task add_req(input logic func, input logic [COUNT_W-1:0] interval,
                 input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value,
                 input bit drain);
        timer_req_t r;
        r.func     = func;
        r.interval = interval;
        r.code     = code;
        r.value    = value;
        r.drain    = drain;
        req_queue.push_back(r);
    endtask

    // updates the predicted pool for one accepted request and queues the
    // events that a tick fires, marking the last one of the tick
    task predict_timer_pool(input logic func, input logic [COUNT_W-1:0] interval,
                            input logic [CODE_W-1:0] code,
                            input logic [VALUE_W-1:0] value);
        int           n;
        bit           placed;
        bit           have_held;
        fired_event_t held;
        n = 0;
        placed = 1'b0;
        have_held = 1'b0;
        if (func == FUNC_START) begin
            // zero interval or a full pool drops the request
            if (interval != '0) begin
                for (int s = 0; s < TIMER_SLOTS; s++) begin
                    if (!placed && pool_count[s] == '0) begin
                        pool_count[s] = interval;
                        pool_code[s]  = code;
                        pool_value[s] = value;
                        placed = 1'b1;
                    end
                end
            end
        end else begin
            for (int s = 0; s < TIMER_SLOTS; s++) begin
                if (pool_count[s] != '0) begin
                    if (pool_count[s] == 1 && n < RESULT_CAP) begin
                        // the previous event is not the last one of this tick
                        if (have_held) begin
                            fired_queue.push_back(held);
                        end
                        held.code  = pool_code[s];
                        held.value = pool_value[s];
                        held.last  = 1'b0;
                        have_held  = 1'b1;
                        n++;
                    end
                    pool_count[s] = pool_count[s] - 1'b1;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                fired_queue.push_back(held);
            end
        end
    endtask

    // driver: payload and valid change at the falling edge only
    always @(negedge i_clk) begin : drive_requests
        timer_req_t nxt;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_idle_window || ($urandom_range(99) >= 36);
            // a valid transaction stays up until it is taken
            if (!i_in_valid || req_taken) begin
                if (req_queue.size() == 0
                    || (!no_idle_window && $urandom_range(99) < 36)
                    || (req_queue[0].drain && fired_queue.size() != 0)) begin
                    i_in_valid <= 1'b0;
                end else begin
                    nxt = req_queue.pop_front();
                    i_in_valid      <= 1'b1;
                    i_func          <= nxt.func;
                    i_interval      <= nxt.interval;
                    i_code_to_send  <= nxt.code;
                    i_value_to_send <= nxt.value;
                end
            end
        end
    end

    // monitor: checks fired events first, then predicts from the request
    // taken at the same edge, since that request cannot fire before it
    always @(posedge i_clk) begin : watch_pool
        fired_event_t want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            for (int s = 0; s < TIMER_SLOTS; s++) begin
                pool_count[s] = '0;
                pool_code[s]  = '0;
                pool_value[s] = '0;
            end
        end else begin
            req_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (fired_queue.size() == 0) begin
                    $error("fired event with none expected: code %0h value %0h last %0b",
                           o_fired_code, o_fired_value, o_last_of_run);
                    err_cnt++;
                end else begin
                    want = fired_queue.pop_front();
                    if (o_fired_code !== want.code) begin
                        $error("fired_code mismatch: expected %0h, actual %0h",
                               want.code, o_fired_code);
                        err_cnt++;
                    end
                    if (o_fired_value !== want.value) begin
                        $error("fired_value mismatch: expected %0h, actual %0h",
                               want.value, o_fired_value);
                        err_cnt++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $error("last_of_run mismatch: expected %0b, actual %0b",
                               want.last, o_last_of_run);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_timer_pool(i_func, i_interval, i_code_to_send, i_value_to_send);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("software_timer_pool_unit test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int          r;
        logic [15:0] iv;
        // tick on an empty pool, then a zero interval start that is dropped
        add_req(FUNC_TICK, 16'd0, 8'h00, 8'h00, 1'b0);
        add_req(FUNC_START, 16'd0, 8'hFF, 8'hFF, 1'b0);
        add_req(FUNC_TICK, 16'd0, 8'h00, 8'h00, 1'b0);
        // single timer firing on the next tick
        add_req(FUNC_START, 16'd1, 8'hFF, 8'h00, 1'b0);
        add_req(FUNC_TICK, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
        // fill every slot, then a start into the full pool is dropped
        for (int s = 0; s < TIMER_SLOTS; s++) begin
            add_req(FUNC_START, 16'd3, 8'(8'h11 * s), 8'(~(8'h11 * s)), 1'b0);
        end
        add_req(FUNC_START, 16'hFFFF, 8'hA5, 8'h5A, 1'b0);
        // all slots expire together on the third tick
        repeat (3) add_req(FUNC_TICK, 16'd0, 8'h00, 8'h00, 1'b0);
        // slot reuse: the upper slot frees first and takes the next start
        add_req(FUNC_START, 16'd2, 8'h01, 8'h10, 1'b1);
        add_req(FUNC_START, 16'd1, 8'h02, 8'h20, 1'b0);
        add_req(FUNC_TICK, 16'd0, 8'h00, 8'h00, 1'b0);
        add_req(FUNC_START, 16'd3, 8'h03, 8'h30, 1'b0);
        repeat (3) add_req(FUNC_TICK, 16'd0, 8'h00, 8'h00, 1'b0);

        // random mix: mostly short intervals so slots keep cycling, with a
        // few zero and longer intervals; ticks carry random unused payload
        for (int n = 0; n < RANDOM_REQS; n++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                r = $urandom_range(99);
                if (r < 5) begin
                    iv = 16'd0;
                end else if (r < 12) begin
                    iv = 16'($urandom_range(200, 13));
                end else begin
                    iv = 16'($urandom_range(12, 1));
                end
                add_req(FUNC_START, iv, 8'($urandom()), 8'($urandom()),
                        (n % 100) == 50);
            end else begin
                add_req(FUNC_TICK, 16'($urandom()), 8'($urandom()), 8'($urandom()),
                        (n % 100) == 50);
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to be taken and every event to be seen
        while (req_queue.size() != 0 || i_in_valid || fired_queue.size() != 0) begin
            @(posedge i_clk);
        end
        // let any straggler surface
        repeat (4 * (TIMER_SLOTS + 2)) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("software_timer_pool_unit test passed");
        end else begin
            $display("software_timer_pool_unit test failed");
        end
        $finish;
    end

endmodule
